FILE: design/pme_pkg.sv
// Package for the permutation move engine: sizes, move codes and the move descriptor.
// No dependencies.
package pme_pkg;

  localparam int MAX_ITEMS  = 64;
  localparam int IDENT_BITS = 16;
  localparam int POS_W      = 6;
  localparam int LEN_W      = 7;
  localparam int OP_W       = 3;

  localparam logic [LEN_W-1:0] LEN_MIN = 7'd2;
  localparam logic [LEN_W-1:0] LEN_MAX = 7'd64;

  localparam logic [OP_W-1:0] OP_LOAD     = 3'd0;
  localparam logic [OP_W-1:0] OP_SWAP     = 3'd1;
  localparam logic [OP_W-1:0] OP_NBR_LEFT = 3'd2;
  localparam logic [OP_W-1:0] OP_NBR_RGHT = 3'd3;
  localparam logic [OP_W-1:0] OP_ROTATE   = 3'd4;
  localparam logic [OP_W-1:0] OP_INS_LATE = 3'd5;
  localparam logic [OP_W-1:0] OP_INS_EARL = 3'd6;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_b;
    logic [LEN_W-1:0] len;
  } move_t;

endpackage

FILE: design/permutation_move_engine_core.sv
// Permutation move engine top level: ping-pong order store, sweep control, stream ports.
// Depends on pme_pkg and pme_addr.
// Flow: a load writes one store entry with no result; an invalid move registers an error result.
// A valid move copies all 64 entries through the single read port, each read into rdata and then
// registered as a result for positions below the move's length, position 0 first, one result
// per cycle while the output is not stalled; no new input is taken until the sweep ends.
// Reset: control state cleared, list_length back to 64; store contents undefined until loaded.
module permutation_move_engine_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // opcode[2:0], pos_a[8:3], pos_b[14:9], load_value[30:15]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_index[5:0], out_ident[21:6]
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data        // list_length
);
  import pme_pkg::*;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;
  localparam int   ADDR_W   = POS_W + 1;

  logic [IDENT_BITS-1:0] store [2*MAX_ITEMS];

  logic                  state;
  logic                  cur;
  logic [LEN_W-1:0]      list_length;
  move_t                 mv;
  logic [LEN_W-1:0]      rd_i;
  logic                  rd_vld;
  logic [POS_W-1:0]      rd_idx;
  logic [IDENT_BITS-1:0] rdata;

  logic                  out_valid;
  logic [POS_W-1:0]      out_index;
  logic [IDENT_BITS-1:0] out_ident;
  logic                  out_last;
  logic                  out_status;

  logic [OP_W-1:0]       in_op;
  logic [POS_W-1:0]      in_a;
  logic [POS_W-1:0]      in_b;
  logic [IDENT_BITS-1:0] in_val;
  logic [LEN_W-1:0]      n_eff;
  logic [LEN_W-1:0]      a_ext;
  logic [LEN_W-1:0]      b_ext;
  logic                  move_ok;
  logic                  accept;
  logic                  is_load;
  logic                  stall;
  logic                  issue;
  logic                  in_list;
  logic                  emit_sweep;
  logic                  emit_err;
  logic [POS_W-1:0]      src;

  assign in_op  = s_axis_tdata[2:0];
  assign in_a   = s_axis_tdata[8:3];
  assign in_b   = s_axis_tdata[14:9];
  assign in_val = s_axis_tdata[30:15];
  assign a_ext  = {1'b0, in_a};
  assign b_ext  = {1'b0, in_b};

  always_comb begin
    priority if (list_length < LEN_MIN) n_eff = LEN_MIN;
    else if (list_length > LEN_MAX)     n_eff = LEN_MAX;
    else                                n_eff = list_length;
  end

  always_comb begin
    unique case (in_op)
      OP_SWAP:     move_ok = (a_ext < n_eff) && (b_ext < n_eff) && (in_a != in_b);
      OP_NBR_LEFT: move_ok = (in_a != 6'd0) && (a_ext < n_eff);
      OP_NBR_RGHT: move_ok = ((a_ext + 7'd1) < n_eff);
      OP_ROTATE:   move_ok = (a_ext < n_eff);
      OP_INS_LATE: move_ok = (in_a < in_b) && (b_ext < n_eff);
      OP_INS_EARL: move_ok = (in_b < in_a) && (a_ext < n_eff);
      default:     move_ok = 1'b0;
    endcase
  end

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE) && (!out_valid || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_load       = (in_op == OP_LOAD);

  assign in_list    = ({1'b0, rd_idx} < mv.len);
  assign stall      = rd_vld && in_list && out_valid && !m_axis_tready;
  assign issue      = (state == ST_SWEEP) && !stall && !rd_i[LEN_W-1];
  assign emit_sweep = rd_vld && !stall && in_list;
  assign emit_err   = accept && !is_load && !move_ok;

  pme_addr u_addr (
    .mv  (mv),
    .idx (rd_i[POS_W-1:0]),
    .src (src)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= LEN_MAX;
    end else if (cfg_valid && cfg_ready) begin
      list_length <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cur    <= 1'b0;
      rd_vld <= 1'b0;
      rd_i   <= '0;
    end else begin
      if (accept && !is_load && move_ok) begin
        state <= ST_SWEEP;
        rd_i  <= '0;
      end
      if (state == ST_SWEEP && !stall) begin
        rd_vld <= issue;
        if (issue) begin
          rd_i <= rd_i + 7'd1;
        end
        if (rd_vld && rd_idx == POS_W'(MAX_ITEMS - 1)) begin
          state <= ST_IDLE;
          cur   <= ~cur;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_load && move_ok) begin
      mv <= '{op: in_op, pos_a: in_a, pos_b: in_b, len: n_eff};
    end
    if (issue) begin
      rd_idx <= rd_i[POS_W-1:0];
    end
  end

  // store: lower half is bank 0, upper half bank 1; a move copies cur into ~cur
  always_ff @(posedge clk) begin
    if (accept && is_load) begin
      store[ADDR_W'({cur, in_a})] <= in_val;
    end else if (rd_vld && !stall) begin
      store[ADDR_W'({~cur, rd_idx})] <= rdata;
    end
    if (issue) begin
      rdata <= store[ADDR_W'({cur, src})];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid <= emit_sweep || emit_err;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      if (emit_sweep) begin
        out_index  <= rd_idx;
        out_ident  <= rdata;
        out_last   <= ({1'b0, rd_idx} + 7'd1 == mv.len);
        out_status <= 1'b0;
      end else if (emit_err) begin
        out_index  <= '0;
        out_ident  <= '0;
        out_last   <= 1'b1;
        out_status <= 1'b1;
      end
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_ident, out_index};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_status;

endmodule

FILE: design/pme_addr.sv
// Source address generator: which old position feeds new position idx for a move.
// Depends on pme_pkg.
module pme_addr (
  input  pme_pkg::move_t          mv,
  input  logic [pme_pkg::POS_W-1:0] idx,
  output logic [pme_pkg::POS_W-1:0] src
);
  import pme_pkg::*;

  logic [LEN_W-1:0] rot_sum;
  logic [LEN_W-1:0] rot_wrap;
  logic [POS_W-1:0] partner;
  logic             in_range;

  always_comb begin
    rot_sum  = {1'b0, mv.pos_a} + {1'b0, idx};
    rot_wrap = (rot_sum >= mv.len) ? (rot_sum - mv.len) : rot_sum;
    in_range = ({1'b0, idx} < mv.len);
    unique case (mv.op)
      OP_NBR_LEFT: partner = mv.pos_a - 6'd1;
      OP_NBR_RGHT: partner = mv.pos_a + 6'd1;
      default:     partner = mv.pos_b;
    endcase
    src = idx;
    if (in_range) begin
      unique case (mv.op)
        OP_SWAP, OP_NBR_LEFT, OP_NBR_RGHT: begin
          if (idx == mv.pos_a) src = partner;
          else if (idx == partner) src = mv.pos_a;
        end
        OP_ROTATE: src = rot_wrap[POS_W-1:0];
        OP_INS_LATE: begin
          if (idx == mv.pos_b) src = mv.pos_a;
          else if (idx >= mv.pos_a && idx < mv.pos_b) src = idx + 6'd1;
        end
        OP_INS_EARL: begin
          if (idx == mv.pos_b) src = mv.pos_a;
          else if (idx > mv.pos_b && idx <= mv.pos_a) src = idx - 6'd1;
        end
        default: src = idx;
      endcase
    end
  end

endmodule

FILE: design/pme_checker.sv
// Port-level checks for the permutation move engine, bound to the top level.
// Depends on permutation_move_engine_core.
module pme_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        m_axis_tuser
);

  a_err_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("error result without last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[21:0] == 22'd0)
    else $error("error result with nonzero index or ident");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output transfer changed");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid straight after reset");

  a_busy_no_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser && !m_axis_tlast |-> !(s_axis_tvalid && s_axis_tready))
    else $error("input taken in the middle of a run");

endmodule

bind permutation_move_engine_core pme_checker u_pme_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
